FILE: rtl/tcc_pkg.sv
// Package for the text console cursor engine.
// Holds the character codes, result kinds, register indexes and shared types.
// Depends on nothing.
`default_nettype none

package tcc_pkg;

   localparam logic [7:0] CODE_ENQ   = 8'h05;
   localparam logic [7:0] CODE_BS    = 8'h08;
   localparam logic [7:0] CODE_TAB   = 8'h09;
   localparam logic [7:0] CODE_LF    = 8'h0A;
   localparam logic [7:0] CODE_VT    = 8'h0B;
   localparam logic [7:0] CODE_FF    = 8'h0C;
   localparam logic [7:0] CODE_CR    = 8'h0D;
   localparam logic [7:0] CODE_SPACE = 8'd32;

   localparam logic [1:0] KIND_DRAW   = 2'd0;
   localparam logic [1:0] KIND_SCROLL = 2'd1;
   localparam logic [1:0] KIND_CURSOR = 2'd2;

   localparam logic [7:0] CFG_NUM_COLS    = 8'd0;
   localparam logic [7:0] CFG_NUM_ROWS    = 8'd1;
   localparam logic [7:0] CFG_WRAP_ENABLE = 8'd2;
   localparam logic [7:0] CFG_LF_ADDS_CR  = 8'd3;

   localparam logic [7:0] RESET_NUM_COLS = 8'd80;
   localparam logic [7:0] RESET_NUM_ROWS = 8'd60;

   localparam logic [7:0] MIN_COLS = 8'd8;
   localparam logic [7:0] MIN_ROWS = 8'd2;

   localparam int TOP_MARGIN_PIXELS = 35;

   localparam int TAB_BITS = 3;
   localparam logic [TAB_BITS-1:0] TAB_LAST = 3'd7;

   localparam int CNT_BITS = 4;
   localparam logic [CNT_BITS-1:0] MAX_RESULTS = 4'd10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef enum logic [2:0] {
      OP_PUT = 3'd0,
      OP_TAB = 3'd1,
      OP_NL  = 3'd2,
      OP_BS  = 3'd3,
      OP_CR  = 3'd4,
      OP_ENQ = 3'd5
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  glyph;
      logic        is_lf;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   typedef struct packed {
      logic [7:0] num_cols;
      logic [7:0] num_rows;
      logic       wrap_enable;
      logic       lf_adds_cr;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/tcc_if.sv
// Channel interfaces of the text console cursor engine.
// Byte input, result output and register write channels; no dependencies.
`default_nettype none

interface tcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code;
   modport source (output valid, output code, input ready);
   modport sink (input valid, input code, output ready);
endinterface

interface tcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] cell_col;
   logic [7:0] cell_row;
   logic [7:0] glyph_code;
   logic       last;
   modport source (output valid, output kind, output cell_col, output cell_row,
                   output glyph_code, output last, input ready);
   modport sink (input valid, input kind, input cell_col, input cell_row,
                 input glyph_code, input last, output ready);
endinterface

interface tcc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] reg_index;
   logic [7:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcc_front.sv
// Front end: accepts input bytes and classifies them into console operations.
// Uses tcc_pkg and tcc_req_if; feeds tcc_op_queue.
`default_nettype none

module tcc_front (
   tcc_req_if.sink         req,
   input  logic            q_full,
   output tcc_pkg::push_type push
);

   tcc_pkg::op_type op;

   always_comb begin
      op.kind = tcc_pkg::OP_PUT;
      op.glyph = (req.code < tcc_pkg::CODE_SPACE) ? 8'd0 : req.code;
      op.is_lf = 1'b0;
      case (req.code)
         tcc_pkg::CODE_ENQ: begin
            op.kind = tcc_pkg::OP_ENQ;
         end
         tcc_pkg::CODE_BS: begin
            op.kind = tcc_pkg::OP_BS;
         end
         tcc_pkg::CODE_TAB: begin
            op.kind = tcc_pkg::OP_TAB;
            op.glyph = tcc_pkg::CODE_SPACE;
         end
         tcc_pkg::CODE_CR: begin
            op.kind = tcc_pkg::OP_CR;
         end
         tcc_pkg::CODE_LF: begin
            op.kind = tcc_pkg::OP_NL;
            op.is_lf = 1'b1;
         end
         tcc_pkg::CODE_VT, tcc_pkg::CODE_FF: begin
            op.kind = tcc_pkg::OP_NL;
         end
         default: begin
            op.kind = tcc_pkg::OP_PUT;
         end
      endcase
   end

   assign req.ready = !q_full;
   assign push.valid = req.valid && !q_full;
   assign push.op = op;

endmodule

`default_nettype wire

FILE: rtl/tcc_op_queue.sv
// Short queue of classified operations between the front and back ends.
// Uses tcc_pkg.
`default_nettype none

module tcc_op_queue (
   input  logic              clock,
   input  logic              reset,
   input  tcc_pkg::push_type push,
   input  logic              pop,
   output tcc_pkg::op_type   head,
   output logic              empty,
   output logic              full
);

   tcc_pkg::op_type slot_ff [tcc_pkg::QUEUE_DEPTH];
   logic [tcc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcc_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign empty = (count_ff == '0);
   assign full = (count_ff == (tcc_pkg::QUEUE_PTR_BITS+1)'(tcc_pkg::QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop = pop && !empty;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcc_back.sv
// Back end: executes queued operations on the cursor, at most one result beat per step.
// Uses tcc_pkg and tcc_rsp_if; fed by tcc_op_queue.
`default_nettype none

module tcc_back #(
   parameter int CoordBits = 8,
   parameter int ResetRowValue = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  tcc_pkg::cfg_type cfg,
   input  tcc_pkg::op_type  head,
   input  logic             q_empty,
   output logic             pop,
   tcc_rsp_if.source        rsp
);

   typedef enum logic [2:0] {
      PH_MAIN   = 3'b001,
      PH_WRAP   = 3'b010,
      PH_CURSOR = 3'b100
   } phase_type;

   localparam logic [CoordBits-1:0] ResetRow = CoordBits'(ResetRowValue);
   localparam logic [7:0] ColMax = 8'((1 << CoordBits) - 1);
   localparam logic [8:0] RowMax = 9'(1 << CoordBits);

   phase_type phase_ff, phase_in;
   logic [CoordBits-1:0] col_ff, col_in;
   logic [CoordBits-1:0] row_ff, row_in;
   logic [tcc_pkg::TAB_BITS-1:0] rep_ff, rep_in;
   logic [tcc_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_col_ff;
   logic [7:0] rsp_row_ff;
   logic [7:0] rsp_glyph_ff;
   logic       rsp_last_ff;

   logic [7:0] cols_wide;
   logic [8:0] bottom_wide;
   logic [CoordBits-1:0] cols;
   logic [CoordBits-1:0] bottom;
   logic [CoordBits:0] next_col;
   logic [CoordBits-1:0] col_adv;
   logic [CoordBits-1:0] col_mod;
   logic wrap_hit;
   logic row_low;
   logic visible;
   logic last_put;
   logic more_tab;
   logic out_free;
   logic step;
   logic emit;
   logic fire;
   logic finish;
   logic [1:0] e_kind;
   logic [CoordBits-1:0] e_col;
   logic [CoordBits-1:0] e_row;
   logic [7:0] e_glyph;
   logic e_last;

   always_comb begin
      if (cfg.num_cols < tcc_pkg::MIN_COLS) begin
         cols_wide = tcc_pkg::MIN_COLS;
      end else if (cfg.num_cols > ColMax) begin
         cols_wide = ColMax;
      end else begin
         cols_wide = cfg.num_cols;
      end
      if (cfg.num_rows < tcc_pkg::MIN_ROWS) begin
         bottom_wide = 9'({1'b0, tcc_pkg::MIN_ROWS} - 9'd1);
      end else if ({1'b0, cfg.num_rows} > RowMax) begin
         bottom_wide = RowMax - 9'd1;
      end else begin
         bottom_wide = {1'b0, cfg.num_rows} - 9'd1;
      end
   end

   assign cols = cols_wide[CoordBits-1:0];
   assign bottom = bottom_wide[CoordBits-1:0];

   assign next_col = {1'b0, col_ff} + 1'b1;
   assign wrap_hit = cfg.wrap_enable && (next_col >= {1'b0, cols});
   assign row_low = row_ff < bottom;
   assign visible = (col_ff < cols) && (row_ff <= bottom);
   assign last_put = (head.kind != tcc_pkg::OP_TAB) || (rep_ff == tcc_pkg::TAB_LAST);
   assign more_tab = (head.kind == tcc_pkg::OP_TAB) && (rep_ff != '0);

   always_comb begin
      if (cfg.wrap_enable) begin
         col_adv = wrap_hit ? '0 : next_col[CoordBits-1:0];
      end else begin
         col_adv = (next_col > {1'b0, cols}) ? cols : next_col[CoordBits-1:0];
      end
      case (head.kind)
         tcc_pkg::OP_BS: begin
            col_mod = (col_ff != '0) ? col_ff - 1'b1 : col_ff;
         end
         tcc_pkg::OP_CR: begin
            col_mod = '0;
         end
         default: begin
            col_mod = col_ff;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign step = !q_empty && out_free;

   always_comb begin
      phase_in = phase_ff;
      col_in = col_ff;
      row_in = row_ff;
      rep_in = rep_ff;
      finish = 1'b0;
      emit = 1'b0;
      e_kind = tcc_pkg::KIND_CURSOR;
      e_col = col_ff;
      e_row = row_ff;
      e_glyph = 8'd0;
      e_last = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_MAIN: begin
               case (head.kind)
                  tcc_pkg::OP_PUT, tcc_pkg::OP_TAB: begin
                     emit = visible;
                     e_kind = tcc_pkg::KIND_DRAW;
                     e_glyph = head.glyph;
                     col_in = col_adv;
                     rep_in = rep_ff + 1'b1;
                     if (wrap_hit && !row_low) begin
                        phase_in = PH_WRAP;
                     end else begin
                        if (wrap_hit) begin
                           row_in = row_ff + 1'b1;
                        end
                        phase_in = last_put ? PH_CURSOR : PH_MAIN;
                     end
                  end
                  tcc_pkg::OP_NL: begin
                     if (row_low) begin
                        row_in = row_ff + 1'b1;
                     end else begin
                        emit = 1'b1;
                        e_kind = tcc_pkg::KIND_SCROLL;
                        e_col = '0;
                        e_row = bottom;
                        row_in = bottom;
                     end
                     if (head.is_lf && cfg.lf_adds_cr) begin
                        col_in = '0;
                     end
                     phase_in = PH_CURSOR;
                  end
                  default: begin
                     emit = 1'b1;
                     e_col = col_mod;
                     e_last = 1'b1;
                     col_in = col_mod;
                     finish = 1'b1;
                  end
               endcase
            end
            PH_WRAP: begin
               emit = 1'b1;
               e_kind = tcc_pkg::KIND_SCROLL;
               e_col = '0;
               e_row = bottom;
               row_in = bottom;
               phase_in = more_tab ? PH_MAIN : PH_CURSOR;
            end
            PH_CURSOR: begin
               emit = 1'b1;
               e_last = 1'b1;
               finish = 1'b1;
            end
            default: begin
               phase_in = PH_MAIN;
            end
         endcase
      end
      if (finish) begin
         phase_in = PH_MAIN;
         rep_in = '0;
      end
   end

   assign fire = emit && (cnt_ff < tcc_pkg::MAX_RESULTS);
   assign pop = finish;

   always_comb begin
      cnt_in = cnt_ff;
      if (finish) begin
         cnt_in = '0;
      end else if (fire) begin
         cnt_in = cnt_ff + 1'b1;
      end
      rsp_valid_in = out_free ? fire : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_kind_ff <= e_kind;
         rsp_col_ff <= 8'(e_col);
         rsp_row_ff <= 8'(e_row);
         rsp_glyph_ff <= e_glyph;
         rsp_last_ff <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAIN;
         col_ff <= '0;
         row_ff <= ResetRow;
         rep_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rep_ff <= rep_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind = rsp_kind_ff;
   assign rsp.cell_col = rsp_col_ff;
   assign rsp.cell_row = rsp_row_ff;
   assign rsp.glyph_code = rsp_glyph_ff;
   assign rsp.last = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: register file, front end,
// operation queue and back end. Uses tcc_pkg, tcc_if, tcc_front, tcc_op_queue, tcc_back.
//
//   channel   direction  beat
//   req_bus   in         one character byte (code)
//   rsp_bus   out        one cell command or the cursor position (last on the cursor)
//   csr_bus   in         one register write (reg_index, wdata), always ready
//
// Each back-end step gives at most one result beat, a dropped draw
// included: a printable byte takes two steps, three when its wrap scrolls, a line feed
// two, backspace, carriage return and 0x05 one, and a tab nine, or ten with a scroll.
// The front end takes a byte every cycle while the four-entry queue has room; a stalled
// result holds the back end, and the front end keeps taking bytes until the queue fills.
// Reset puts the cursor at column 0, row 35 / GLYPH_HEIGHT + 1, with the register defaults.
`default_nettype none

module text_console_cursor_engine #(
   parameter int GLYPH_HEIGHT = 8,
   parameter int COORD_WIDTH = 8
) (
   input  wire        clock,
   input  wire        reset,
   tcc_req_if.sink    req_bus,
   tcc_rsp_if.source  rsp_bus,
   tcc_csr_if.sink    csr_bus
);

   localparam int CoordBits = (COORD_WIDTH < 8) ? COORD_WIDTH : 8;
   localparam int ResetRowValue = tcc_pkg::TOP_MARGIN_PIXELS / GLYPH_HEIGHT + 1;

   tcc_pkg::cfg_type cfg_ff, cfg_in;
   tcc_pkg::push_type push;
   tcc_pkg::op_type head;
   logic q_empty;
   logic q_full;
   logic pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            tcc_pkg::CFG_NUM_COLS: begin
               cfg_in.num_cols = csr_bus.wdata;
            end
            tcc_pkg::CFG_NUM_ROWS: begin
               cfg_in.num_rows = csr_bus.wdata;
            end
            tcc_pkg::CFG_WRAP_ENABLE: begin
               cfg_in.wrap_enable = csr_bus.wdata[0];
            end
            tcc_pkg::CFG_LF_ADDS_CR: begin
               cfg_in.lf_adds_cr = csr_bus.wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_cols <= tcc_pkg::RESET_NUM_COLS;
         cfg_ff.num_rows <= tcc_pkg::RESET_NUM_ROWS;
         cfg_ff.wrap_enable <= 1'b1;
         cfg_ff.lf_adds_cr <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_bus.ready = 1'b1;

   tcc_front u_front (
      .req    (req_bus),
      .q_full (q_full),
      .push   (push)
   );

   tcc_op_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (q_empty),
      .full  (q_full)
   );

   tcc_back #(
      .CoordBits     (CoordBits),
      .ResetRowValue (ResetRowValue)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp     (rsp_bus)
   );

`ifndef SYNTHESIS
   // The final beat of a byte is always its cursor position, and only that one.
   a_last_is_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last |-> rsp_bus.kind == tcc_pkg::KIND_CURSOR)
      else $error("last beat is not a cursor result");

   a_cursor_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == tcc_pkg::KIND_CURSOR |-> rsp_bus.last)
      else $error("cursor result without last");

   // A scroll beat names the cleared row only.
   a_scroll_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == tcc_pkg::KIND_SCROLL
      |-> rsp_bus.cell_col == 8'd0 && rsp_bus.glyph_code == 8'd0)
      else $error("scroll result carries a column or glyph");

   // The queue never takes a byte while it reports itself full.
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push.valid && !req_bus.ready)
      else $error("byte accepted into a full queue");
`endif

endmodule

`default_nettype wire

FILE: dv/text_console_cursor_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console cursor engine: byte, result and
// register channels, random idling on the first two, checked against a cursor predictor.
// Depends on tcc_pkg, the tcc_if interfaces and text_console_cursor_engine.

module text_console_cursor_engine_test;

   localparam int GLYPH_HEIGHT = 8;
   localparam int COORD_WIDTH = 8;
   localparam int COORD_MAX = (1 << COORD_WIDTH) - 1;
   localparam int TAB_SPACES = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES = 10;
   localparam int DIRECTED_COUNT = 19;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] glyph;
      logic       last;
   } cell_cmd_type;

   class console_scoreboard;
      int cols_reg;
      int rows_reg;
      bit wrap_on;
      bit lf_cr;
      int cur_col;
      int cur_row;
      int emitted;
      cell_cmd_type expected_cmds[$];
      int mismatches;
      int bytes_seen;
      int results_checked;
      int scrolls_checked;

      function new();
         cols_reg = tcc_pkg::RESET_NUM_COLS;
         rows_reg = tcc_pkg::RESET_NUM_ROWS;
         wrap_on = 1'b1;
         lf_cr = 1'b1;
         cur_col = 0;
         cur_row = (tcc_pkg::TOP_MARGIN_PIXELS / GLYPH_HEIGHT + 1) & COORD_MAX;
         emitted = 0;
         mismatches = 0;
         bytes_seen = 0;
         results_checked = 0;
         scrolls_checked = 0;
      endfunction

      function void set_reg(logic [7:0] index, logic [7:0] value);
         case (index)
            tcc_pkg::CFG_NUM_COLS: cols_reg = value;
            tcc_pkg::CFG_NUM_ROWS: rows_reg = value;
            tcc_pkg::CFG_WRAP_ENABLE: wrap_on = value[0];
            tcc_pkg::CFG_LF_ADDS_CR: lf_cr = value[0];
            default: ;
         endcase
      endfunction

      function int col_count();
         int c;
         c = cols_reg;
         if (c < tcc_pkg::MIN_COLS) c = tcc_pkg::MIN_COLS;
         if (c > COORD_MAX) c = COORD_MAX;
         return c;
      endfunction

      function int row_count();
         int r;
         r = rows_reg;
         if (r < tcc_pkg::MIN_ROWS) r = tcc_pkg::MIN_ROWS;
         if (r > COORD_MAX + 1) r = COORD_MAX + 1;
         return r;
      endfunction

      function int pending();
         return expected_cmds.size();
      endfunction

      function void push_cmd(logic [1:0] kind, int col, int row, logic [7:0] glyph,
                             bit last);
         cell_cmd_type cmd;
         if (emitted >= int'(tcc_pkg::MAX_RESULTS)) return;
         cmd.kind = kind;
         cmd.col = col[7:0];
         cmd.row = row[7:0];
         cmd.glyph = glyph;
         cmd.last = last;
         expected_cmds.push_back(cmd);
         emitted++;
      endfunction

      function void line_down();
         int bottom;
         bottom = row_count() - 1;
         if (cur_row < bottom) begin
            cur_row++;
         end else begin
            push_cmd(tcc_pkg::KIND_SCROLL, 0, bottom, 8'd0, 1'b0);
            cur_row = bottom;
         end
      endfunction

      function void put_glyph(logic [7:0] ch);
         int cols;
         int next;
         logic [7:0] glyph;
         cols = col_count();
         next = cur_col + 1;
         glyph = (ch < tcc_pkg::CODE_SPACE) ? 8'd0 : ch;
         // Draws that fall off the grid are dropped, but the cursor still moves.
         if (cur_col < cols && cur_row < row_count())
            push_cmd(tcc_pkg::KIND_DRAW, cur_col, cur_row, glyph, 1'b0);
         if (wrap_on) begin
            if (next >= cols) begin
               cur_col = 0;
               line_down();
            end else begin
               cur_col = next;
            end
         end else begin
            cur_col = (next > cols) ? cols : next;
         end
      endfunction

      function void note_input(logic [7:0] code);
         emitted = 0;
         bytes_seen++;
         case (code)
            tcc_pkg::CODE_ENQ: ;
            tcc_pkg::CODE_BS: if (cur_col > 0) cur_col--;
            tcc_pkg::CODE_TAB: begin
               for (int i = 0; i < TAB_SPACES; i++) put_glyph(tcc_pkg::CODE_SPACE);
            end
            tcc_pkg::CODE_CR: cur_col = 0;
            tcc_pkg::CODE_LF, tcc_pkg::CODE_VT, tcc_pkg::CODE_FF: begin
               line_down();
               if (code == tcc_pkg::CODE_LF && lf_cr) cur_col = 0;
            end
            default: put_glyph(code);
         endcase
         push_cmd(tcc_pkg::KIND_CURSOR, cur_col, cur_row, 8'd0, 1'b1);
      endfunction

      task report(string what);
         mismatches++;
         $display("ERROR at %0t: %s", $time, what);
      endtask

      task check_result(cell_cmd_type got);
         cell_cmd_type want;
         if (expected_cmds.size() == 0) begin
            report($sformatf("unexpected beat kind %0d col %0d row %0d glyph %0d last %0d",
                             got.kind, got.col, got.row, got.glyph, got.last));
            return;
         end
         want = expected_cmds.pop_front();
         results_checked++;
         if (want.kind == tcc_pkg::KIND_SCROLL) scrolls_checked++;
         if (got.kind !== want.kind || got.col !== want.col || got.row !== want.row ||
             got.glyph !== want.glyph || got.last !== want.last)
            report($sformatf({"beat %0d: kind/col/row/glyph/last %0d/%0d/%0d/%0d/%0d,",
                              " want %0d/%0d/%0d/%0d/%0d"},
                             results_checked, got.kind, got.col, got.row, got.glyph,
                             got.last, want.kind, want.col, want.row, want.glyph,
                             want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int settings_written = 0;
   console_scoreboard sb;

   logic [7:0] special_codes [DIRECTED_COUNT] = '{
      8'h00, tcc_pkg::CODE_ENQ, tcc_pkg::CODE_BS, tcc_pkg::CODE_BS, 8'h41,
      tcc_pkg::CODE_CR, tcc_pkg::CODE_TAB, tcc_pkg::CODE_LF, tcc_pkg::CODE_VT,
      tcc_pkg::CODE_FF, 8'h1F, 8'h1B, tcc_pkg::CODE_SPACE, 8'h7E, 8'h7F, 8'h80,
      8'hFF, 8'h55, 8'hAA
   };

   tcc_req_if req_bus ();
   tcc_rsp_if rsp_bus ();
   tcc_csr_if csr_bus ();

   text_console_cursor_engine #(
      .GLYPH_HEIGHT(GLYPH_HEIGHT),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : beat_monitor
      cell_cmd_type seen;
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) sb.note_input(req_bus.code);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen.kind = rsp_bus.kind;
            seen.col = rsp_bus.cell_col;
            seen.row = rsp_bus.cell_row;
            seen.glyph = rsp_bus.glyph_code;
            seen.last = rsp_bus.last;
            sb.check_result(seen);
         end
      end
   end

   initial begin : rsp_driver
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(0, 99) < 31);
         end
      end
   end

   function automatic logic [7:0] pick_code();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 8'($urandom_range(32, 126));
      if (roll < 55) return 8'($urandom_range(127, 255));
      if (roll < 80) begin
         case ($urandom_range(0, 6))
            0: return tcc_pkg::CODE_ENQ;
            1: return tcc_pkg::CODE_BS;
            2: return tcc_pkg::CODE_TAB;
            3: return tcc_pkg::CODE_LF;
            4: return tcc_pkg::CODE_VT;
            5: return tcc_pkg::CODE_FF;
            default: return tcc_pkg::CODE_CR;
         endcase
      end
      if (roll < 90) return 8'($urandom_range(0, 31));
      return 8'($urandom());
   endfunction

   task automatic send_byte(logic [7:0] value);
      while (idle_on && $urandom_range(0, 99) < 31) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.code <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_byte(pick_code());
   endtask

   // The first edge lets the monitor note a beat taken at the current edge.
   task automatic wait_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_settings(int cols, int rows, bit wrap, bit lfcr);
      logic [7:0] values [4];
      values[tcc_pkg::CFG_NUM_COLS] = cols[7:0];
      values[tcc_pkg::CFG_NUM_ROWS] = rows[7:0];
      values[tcc_pkg::CFG_WRAP_ENABLE] = {7'd0, wrap};
      values[tcc_pkg::CFG_LF_ADDS_CR] = {7'd0, lfcr};
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int idx = 0; idx < 4; idx++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.reg_index <= 8'(idx);
         csr_bus.wdata <= values[idx];
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         sb.set_reg(8'(idx), values[idx]);
      end
      csr_bus.valid <= 1'b0;
      settings_written++;
   endtask

   initial begin : stimulus
      int cols;
      int rows;
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.code = 8'd0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = 8'd0;
      csr_bus.wdata = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (special_codes[i]) send_byte(special_codes[i]);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_settings(tcc_pkg::RESET_NUM_COLS, tcc_pkg::RESET_NUM_ROWS, 1'b1, 1'b1);
            1: write_settings(tcc_pkg::MIN_COLS, tcc_pkg::MIN_ROWS, 1'b1, 1'b0);
            2: write_settings(255, 255, 1'b0, 1'b1);
            3: write_settings(0, 0, 1'b1, 1'b1);
            4: write_settings(3, 1, 1'b0, 1'b0);
            default: begin
               cols = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(8, 24);
               rows = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(2, 8);
               write_settings(cols, rows, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
         endcase
         idle_on = (p != 0);
         if (p == 1) hold_request = 1'b1;
         if (p == 0) begin
            send_random(60);
         end else begin
            send_random(19);
            if (p == 3) wait_results();
            send_random(19);
         end
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d bytes over %0d register settings; %0d beats checked, %0d scrolls.",
               sb.bytes_seen, settings_written, sb.results_checked, sb.scrolls_checked);
      $display("Included directed codes, a long result hold-off, a drained pause and idling.");
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
